// ===== rtl/bba_pkg.sv =====
// Shared constants, types and codes of the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int IDX_W     = ADDR_W + BIT_W;
    localparam int LIM_W     = IDX_W + 1;

    localparam int BLK_W     = 16;
    localparam int SB_W      = 13;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int CMP_W     = (SB_W > LIM_W) ? SB_W : LIM_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [BIT_W-1:0]     t_bitpos;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [LIM_W-1:0]     t_limit;
    typedef logic [BLK_W-1:0]     t_blk;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_NULL    = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_VALID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BITS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BLOCK_COUNT = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/bba_map_ram.sv =====
// Map word memory with per-row valid flags; unwritten rows read as zero.
`default_nettype none

module bba_map_ram (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_rd_en,
    input  bba_pkg::t_addr   i_rd_addr,
    output bba_pkg::t_word   o_rd_data,
    input  wire              i_wr_en,
    input  bba_pkg::t_addr   i_wr_addr,
    input  bba_pkg::t_word   i_wr_data
);
    import bba_pkg::*;

    t_word                mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_row_vld;
    t_word                r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/bba_first_zero.sv =====
// Lowest clear bit of a map word within a search mask.
`default_nettype none

module bba_first_zero (
    input  bba_pkg::t_word   i_word,
    input  bba_pkg::t_word   i_mask,
    output logic             o_found,
    output bba_pkg::t_bitpos o_pos,
    output bba_pkg::t_word   o_onehot
);
    import bba_pkg::*;

    t_word cand;

    assign cand     = ~i_word & i_mask;
    assign o_onehot = cand & (~cand + t_word'(1));
    assign o_found  = |cand;

    always_comb begin
        o_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            for (int k = 0; k < BIT_W; k++) begin
                if (o_onehot[j] && ((j >> k) & 1) == 1) begin
                    o_pos[k] = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_block_allocator_core.sv =====
// Top level of the first-fit bitmap block allocator.
//
// Requests arrive one at a time on the slave stream (tuser 0 allocate, 1 free) and each
// gives one result on the master stream. The 4096-bit map sits in a 64-bit-wide memory
// with one read and one write port; rows carry valid flags cleared by reset, so no clearing
// pass is needed and the first request may follow reset at once. An allocate scans one map
// word per cycle, from word 0 up to a hit or to the last searched word. A free is a
// read-modify-write of one word; a rejected request goes straight to its result. The next
// request is accepted once the result is in the output register, while that result still
// waits to be taken.
`default_nettype none

module bitmap_block_allocator_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [bba_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [bba_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [15:0] block_number
    input  wire  [bba_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    // [0] operation
    input  wire                                   i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // [15:0] allocated_block, [18:16] status, [23:19] zero
    output logic [bba_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);
    import bba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_FREE_WR,
        S_DONE
    } t_state;

    logic            r_vol;
    t_blk            r_fdb;
    logic [SB_W-1:0] r_sb;
    t_blk            r_dbc;

    t_state  r_state, n_state;
    t_addr   r_word, n_word;
    t_idx    r_idx, n_idx;
    t_blk    r_res_blk, n_res_blk;
    t_status r_res_st, n_res_st;
    logic    r_out_valid, n_out_valid;
    t_blk    r_out_blk, n_out_blk;
    t_status r_out_st, n_out_st;

    logic    rd_en, wr_en;
    t_addr   rd_addr, wr_addr;
    t_word   rd_data, wr_data;

    logic    in_acc;
    t_limit  limit, lim_m1;
    logic [LIM_W-BIT_W-1:0] lim_word;
    t_bitpos lim_bit;
    t_addr   w_last;
    t_word   mask;
    logic    found;
    t_bitpos pos;
    t_word   onehot;
    t_blk    blk_in, free_idx;
    logic    free_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= 1'b0;
            r_fdb <= '0;
            r_sb  <= SB_W'(4096);
            r_dbc <= BLK_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOLUME_VALID:     r_vol <= i_cfg_data[0];
                CFG_FIRST_DATA_BLOCK: r_fdb <= i_cfg_data[BLK_W-1:0];
                CFG_SEARCH_BITS:      r_sb  <= i_cfg_data[SB_W-1:0];
                CFG_DATA_BLOCK_COUNT: r_dbc <= i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign blk_in = i_s_axis_tdata[BLK_W-1:0];

    assign limit    = (CMP_W'(r_sb) > CMP_W'(MAP_BITS)) ? LIM_W'(MAP_BITS) : LIM_W'(r_sb);
    assign lim_m1   = limit - t_limit'(1);
    assign lim_word = limit[LIM_W-1:BIT_W];
    assign lim_bit  = limit[BIT_W-1:0];
    assign w_last   = lim_m1[IDX_W-1:BIT_W];

    always_comb begin
        if ({1'b0, r_word} < lim_word) begin
            mask = '1;
        end else if ({1'b0, r_word} == lim_word) begin
            mask = (t_word'(1) << lim_bit) - t_word'(1);
        end else begin
            mask = '0;
        end
    end

    assign free_idx      = blk_in - r_fdb;
    assign free_in_range = (free_idx < r_dbc) &&
                           ({1'b0, free_idx} < (BLK_W + 1)'(MAP_BITS));

    bba_map_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    bba_first_zero u_find (
        .i_word   (rd_data),
        .i_mask   (mask),
        .o_found  (found),
        .o_pos    (pos),
        .o_onehot (onehot)
    );

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_idx       = r_idx;
        n_res_blk   = r_res_blk;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_blk   = r_out_blk;
        n_out_st    = r_out_st;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_word;
        wr_data     = rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_blk = '0;
                    if (!r_vol) begin
                        n_res_st = ST_INVALID;
                        n_state  = S_DONE;
                    end else if (i_s_axis_tuser == OP_ALLOC) begin
                        n_word = '0;
                        if (limit == '0) begin
                            n_res_st = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_CHK;
                        end
                    end else if (blk_in == '0) begin
                        n_res_st = ST_NULL;
                        n_state  = S_DONE;
                    end else if (blk_in < r_fdb || !free_in_range) begin
                        n_res_st = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = free_idx[IDX_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = free_idx[IDX_W-1:BIT_W];
                        n_state = S_FREE_WR;
                    end
                end
            end
            S_CHK: begin
                if (found) begin
                    wr_en     = 1'b1;
                    wr_data   = rd_data | onehot;
                    n_res_blk = r_fdb + BLK_W'({r_word, pos});
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                end else if (r_word == w_last) begin
                    n_res_st = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_word  = r_word + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_word + 1'b1;
                end
            end
            S_FREE_WR: begin
                wr_en    = 1'b1;
                wr_addr  = r_idx[IDX_W-1:BIT_W];
                wr_data  = rd_data & ~(t_word'(1) << r_idx[BIT_W-1:0]);
                n_res_st = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_blk   = r_res_blk;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_word    <= n_word;
        r_idx     <= n_idx;
        r_res_blk <= n_res_blk;
        r_res_st  <= n_res_st;
        r_out_blk <= n_out_blk;
        r_out_st  <= n_out_st;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - BLK_W - ST_W)'(0), r_out_st, r_out_blk};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("request accepted while another is in flight");

    a_fail_zero_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != ST_OK) |-> (r_out_blk == '0))
        else $error("failed result carries a block number");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_word <= w_last))
        else $error("scan ran past the searchable range");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_CHK && found) || r_state == S_FREE_WR))
        else $error("map written outside an update");

endmodule

`default_nettype wire

// ===== verif/bba_tb_pkg.sv =====
// Scoreboard class of the bitmap block allocator testbench: map shadow and pending replies.
`default_nettype none

package bba_tb_pkg;

    import bba_pkg::*;

    typedef struct packed {
        t_status st;
        t_blk    blk;
    } t_reply;

    class alloc_scoreboard;
        bit          used [MAP_BITS];
        int unsigned used_bits;
        bit          volume_ok;
        int unsigned base_block;
        int unsigned scan_bits;
        int unsigned block_count;
        t_reply      owed_replies [$];
        int unsigned failures;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            used_bits   = 0;
            volume_ok   = 1'b0;
            base_block  = 0;
            scan_bits   = 4096;
            block_count = 4096;
            failures    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_VOLUME_VALID:     volume_ok   = val[0];
                CFG_FIRST_DATA_BLOCK: base_block  = val;
                CFG_SEARCH_BITS:      scan_bits   = val[SB_W-1:0];
                CFG_DATA_BLOCK_COUNT: block_count = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction

        // Count the clear bits among the first n map bits.
        function int unsigned clear_below(int unsigned n);
            int unsigned cnt;
            cnt = 0;
            for (int unsigned i = 0; i < n && i < MAP_BITS; i++) begin
                if (!used[i]) cnt++;
            end
            return cnt;
        endfunction

        // Predict the reply of one accepted request and update the map shadow.
        function void note_request(logic op, t_blk blk);
            t_reply      r;
            int unsigned lim;
            int unsigned idx;
            int unsigned i;
            r.blk = '0;
            r.st  = ST_OK;
            if (!volume_ok) begin
                r.st = ST_INVALID;
            end else if (op == OP_ALLOC) begin
                lim  = (scan_bits > MAP_BITS) ? MAP_BITS : scan_bits;
                r.st = ST_FULL;
                for (i = 0; i < lim; i++) begin
                    if (!used[i]) begin
                        used[i] = 1'b1;
                        used_bits++;
                        r.blk = t_blk'(base_block + i);
                        r.st  = ST_OK;
                        break;
                    end
                end
            end else if (blk == '0) begin
                r.st = ST_NULL;
            end else if (blk < base_block) begin
                r.st = ST_RANGE;
            end else begin
                idx = blk - base_block;
                if (idx >= block_count || idx >= MAP_BITS) begin
                    r.st = ST_RANGE;
                end else begin
                    if (used[idx]) used_bits--;
                    used[idx] = 1'b0;
                end
            end
            owed_replies.push_back(r);
        endfunction

        function void check_reply(logic [OUT_TDATA_W-1:0] data, time stamp);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $display("%0d ns: reply %h with no request pending", stamp, data);
                failures++;
                return;
            end
            want = owed_replies.pop_front();
            if (data[BLK_W-1:0] !== want.blk) begin
                $display("%0d ns: allocated_block expected %0d, got %0d",
                         stamp, want.blk, data[BLK_W-1:0]);
                failures++;
            end
            if (data[BLK_W+ST_W-1:BLK_W] !== want.st) begin
                $display("%0d ns: status expected %0d, got %0d",
                         stamp, want.st, data[BLK_W+ST_W-1:BLK_W]);
                failures++;
            end
            if (data[OUT_TDATA_W-1:BLK_W+ST_W] !== '0) begin
                $display("%0d ns: padding expected 0, got %h",
                         stamp, data[OUT_TDATA_W-1:BLK_W+ST_W]);
                failures++;
            end
        endfunction
    endclass

endpackage

`default_nettype wire

// ===== verif/tb_top.sv =====
// Top-level testbench of the bitmap block allocator: stimulus, stream handshakes and checking.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;
    import bba_tb_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int FILL_BITS    = 512;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data  = '0;
    logic                   req_op    = 1'b0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] rsp_data;

    bit                     req_stalls   = 1'b1;
    bit                     rsp_stalls   = 1'b1;
    int unsigned            hold_request = 0;

    alloc_scoreboard board = new();

    always #6 clk = ~clk;

    bitmap_block_allocator_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_op),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data)
    );

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) board.check_reply(rsp_data, $time);
        if (rst_n && req_valid && req_ready) board.note_request(req_op, req_data);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : reply_side
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                rsp_ready = 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
                rsp_ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            rsp_ready = 1'b1;
        end
    end

    task automatic send_request(input logic op, input t_blk blk);
        @(negedge clk);
        if (req_stalls && $urandom_range(0, 5) == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_valid = 1'b1;
        req_op    = op;
        req_data  = blk;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        board.write_reg(idx, val);
    endtask

    task automatic configure(input logic vol, input int unsigned base,
                             input int unsigned scan, input int unsigned count);
        wait_drained();
        write_reg(CFG_VOLUME_VALID, CFG_W'(vol));
        write_reg(CFG_FIRST_DATA_BLOCK, CFG_W'(base));
        write_reg(CFG_SEARCH_BITS, CFG_W'(scan));
        write_reg(CFG_DATA_BLOCK_COUNT, CFG_W'(count));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mix allocations with frees that mostly land near the base, plus null, below-base and noise.
    task automatic random_requests(input int unsigned n, input int unsigned alloc_pct,
                                   input int unsigned span);
        t_blk        blk;
        logic        op;
        int unsigned pick;
        repeat (n) begin
            op   = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            pick = $urandom_range(0, 9);
            if (op == OP_ALLOC || pick == 0) blk = t_blk'($urandom);
            else if (pick == 1) blk = '0;
            else if (pick == 2) blk = t_blk'(board.base_block - 1 - $urandom_range(0, 7));
            else blk = t_blk'(board.base_block + $urandom_range(0, span));
            send_request(op, blk);
        end
    endtask

    task automatic pick_idling();
        req_stalls = ($urandom_range(0, 3) != 0);
        rsp_stalls = ($urandom_range(0, 3) != 0);
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_ALLOC, 16'hFFFF);
        send_request(OP_FREE, 16'h0005);

        configure(1'b1, 0, 4096, 4096);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_ALLOC, 16'hA5A5);
        send_request(OP_FREE, 16'd0);
        send_request(OP_FREE, 16'd1);
        send_request(OP_FREE, 16'd1);
        send_request(OP_FREE, 16'd4096);
        send_request(OP_FREE, 16'hFFFF);
        send_request(OP_ALLOC, 16'h0000);

        configure(1'b1, 100, 4096, 50);
        send_request(OP_FREE, 16'd99);
        send_request(OP_FREE, 16'd100);
        send_request(OP_FREE, 16'd150);
        send_request(OP_FREE, 16'd149);
        send_request(OP_ALLOC, 16'h5A5A);

        configure(1'b1, 100, 0, 50);
        send_request(OP_ALLOC, 16'h0000);

        configure(1'b1, 100, 3, 50);
        send_request(OP_ALLOC, 16'hFFFF);
        send_request(OP_ALLOC, 16'h0000);

        configure(1'b1, 65535, 8191, 65535);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_FREE, 16'hFFFF);
        send_request(OP_FREE, 16'hFFFE);

        configure(1'b1, 0, 4096, 65535);
        send_request(OP_FREE, 16'd5000);
        send_request(OP_FREE, 16'd4095);

        pick_idling();
        configure(1'b1, 0, 4096, 4096);
        random_requests(250, 60, 300);

        pick_idling();
        configure(1'b0, $urandom_range(0, 65535), $urandom_range(0, 8191),
                  $urandom_range(0, 65535));
        random_requests(20, 50, 100);

        pick_idling();
        configure(1'b1, 65535 - $urandom_range(0, 40), 8191, 65535);
        random_requests(100, 55, 200);

        pick_idling();
        configure(1'b1, $urandom_range(1, 3000), $urandom_range(0, 80),
                  $urandom_range(0, 100));
        random_requests(150, 50, 120);

        // Fill the searched part of the map while the reply side holds off at first.
        req_stalls = 1'b1;
        rsp_stalls = 1'b1;
        configure(1'b1, $urandom_range(0, 65535), FILL_BITS, 4096);
        hold_request = 400;
        while (board.clear_below(FILL_BITS) != 0) send_request(OP_ALLOC, t_blk'($urandom));
        repeat (4) send_request(OP_ALLOC, t_blk'($urandom));

        pick_idling();
        configure(1'b1, board.base_block, 4096, $urandom_range(4096, 65535));
        random_requests(100, 35, 4095);
        wait_drained();
        random_requests(100, 35, 4095);

        req_stalls = 1'b0;
        rsp_stalls = 1'b0;
        configure(1'b1, $urandom_range(0, 200), 4097, 4096);
        random_requests(150, 55, 4095);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_first_zero.sv
rtl/bitmap_block_allocator_core.sv
verif/bba_tb_pkg.sv
verif/tb_top.sv
